@@ rtl/swpf_pkg.sv @@
`timescale 1ns / 1ps

package swpf_pkg;

   // Fixed first byte of every notification packet.
   localparam logic [7:0] HDR_BYTE = 8'h03;

   // Register reset values.
   localparam logic [7:0] STABLE_CODE_RST   = 8'd206;
   localparam logic [7:0] CHANGING_CODE_RST = 8'd202;
   localparam logic [7:0] TARE_OPCODE_RST   = 8'd15;
   localparam logic [7:0] LED_OPCODE_RST    = 8'd10;
   localparam logic [7:0] TIMER_OPCODE_RST  = 8'd11;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STABLE_CODE   = 3'd0,
      CSR_CHANGING_CODE = 3'd1,
      CSR_TARE_OPCODE   = 3'd2,
      CSR_LED_OPCODE    = 3'd3,
      CSR_TIMER_OPCODE  = 3'd4
   } csr_index_type;

   // Item kinds on the request channel.
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_COMMAND = 1'b1;

   // Decoded command, passed from the decoder to the core.
   typedef struct packed {
      logic ok;
      logic tare;
      logic led_on;
      logic timer_on;
   } cmd_action_type;

   // One result item.
   typedef struct packed {
      logic [7:0]        status_byte;
      logic signed [15:0] tared_weight;
      logic signed [15:0] weight_delta;
      logic [7:0]        parity_byte;
      logic              cmd_ok;
      logic              led_flag;
      logic              grams_flag;
      logic              timer_flag;
   } rsp_type;

   // XOR of packet bytes 0 through 5.
   function automatic logic [7:0] frame_parity(input logic [7:0]  status,
                                               input logic [15:0] weight,
                                               input logic [15:0] delta);
      frame_parity = HDR_BYTE ^ status ^ weight[15:8] ^ weight[7:0]
                     ^ delta[15:8] ^ delta[7:0];
   endfunction

endpackage

@@ rtl/swpf_cmd_decode.sv @@
`timescale 1ns / 1ps

module swpf_cmd_decode (
   input  logic [55:0]              cmd_packet,
   input  logic [7:0]               tare_opcode,
   input  logic [7:0]               led_opcode,
   input  logic [7:0]               timer_opcode,
   output swpf_pkg::cmd_action_type action
);

   logic [7:0] sum_x;
   logic [7:0] code;
   logic       parity_good;

   always_comb begin
      sum_x = 8'h00;
      for (int i = 0; i < 6; i++) begin
         sum_x = sum_x ^ cmd_packet[55 - 8*i -: 8];
      end
   end

   assign code        = cmd_packet[47:40];
   assign parity_good = (sum_x == cmd_packet[7:0]);

   // Tare wins over LED, LED over timer when opcodes collide.
   always_comb begin
      action = '0;
      priority if (!parity_good) begin
         action.ok = 1'b0;
      end else if (code == tare_opcode) begin
         action.ok   = 1'b1;
         action.tare = 1'b1;
      end else if (code == led_opcode) begin
         action.ok     = 1'b1;
         action.led_on = 1'b1;
      end else if (code == timer_opcode) begin
         action.ok       = 1'b1;
         action.timer_on = 1'b1;
      end else begin
         action.ok = 1'b0;
      end
   end

endmodule

@@ rtl/swpf_core.sv @@
`timescale 1ns / 1ps

module swpf_core #(
   parameter int WEIGHT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     op,
   input  logic signed [15:0]       sample,
   input  swpf_pkg::cmd_action_type action,
   input  logic [7:0]               stable_code,
   input  logic [7:0]               changing_code,
   output swpf_pkg::rsp_type        rsp
);

   logic [WEIGHT_BITS-1:0] last_raw_ff,    last_raw_in;
   logic [WEIGHT_BITS-1:0] tare_offset_ff, tare_offset_in;
   logic [WEIGHT_BITS-1:0] held_weight_ff, held_weight_in;
   logic [WEIGHT_BITS-1:0] held_delta_ff,  held_delta_in;
   logic [7:0]             held_status_ff, held_status_in;
   logic                   led_ff,   led_in;
   logic                   grams_ff, grams_in;
   logic                   timer_ff, timer_in;

   logic signed [31:0]     sample_ext;
   logic [WEIGHT_BITS-1:0] raw;
   logic [31:0]            weight_ext;
   logic [31:0]            delta_ext;

   // Sign-extend the sample, then wrap it to the internal weight width.
   assign sample_ext = 32'(sample);
   assign raw        = sample_ext[WEIGHT_BITS-1:0];

   always_comb begin
      last_raw_in    = last_raw_ff;
      tare_offset_in = tare_offset_ff;
      held_weight_in = held_weight_ff;
      held_delta_in  = held_delta_ff;
      held_status_in = held_status_ff;
      led_in         = led_ff;
      grams_in       = grams_ff;
      timer_in       = timer_ff;
      if (op == swpf_pkg::OP_SAMPLE) begin
         held_status_in = (raw == last_raw_ff) ? stable_code : changing_code;
         held_weight_in = raw - tare_offset_ff;
         held_delta_in  = raw - last_raw_ff;
         last_raw_in    = raw;
      end else begin
         if (action.tare) begin
            tare_offset_in = last_raw_ff;
            held_weight_in = '0;
            held_delta_in  = '0;
            held_status_in = stable_code;
         end
         if (action.led_on) begin
            led_in   = 1'b1;
            grams_in = 1'b1;
         end
         if (action.timer_on) begin
            timer_in = 1'b1;
         end
      end
   end

   // Outputs carry the low 16 bits, zero-filled when the weight is narrower.
   assign weight_ext = 32'(held_weight_in);
   assign delta_ext  = 32'(held_delta_in);

   always_comb begin
      rsp.status_byte  = held_status_in;
      rsp.tared_weight = weight_ext[15:0];
      rsp.weight_delta = delta_ext[15:0];
      rsp.parity_byte  = swpf_pkg::frame_parity(held_status_in, weight_ext[15:0],
                                                delta_ext[15:0]);
      rsp.cmd_ok       = (op == swpf_pkg::OP_SAMPLE) ? 1'b1 : action.ok;
      rsp.led_flag     = led_in;
      rsp.grams_flag   = grams_in;
      rsp.timer_flag   = timer_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= '0;
         tare_offset_ff <= '0;
         held_weight_ff <= '0;
         held_delta_ff  <= '0;
         held_status_ff <= swpf_pkg::STABLE_CODE_RST;
         led_ff         <= 1'b0;
         grams_ff       <= 1'b1;
         timer_ff       <= 1'b0;
      end else if (advance) begin
         last_raw_ff    <= last_raw_in;
         tare_offset_ff <= tare_offset_in;
         held_weight_ff <= held_weight_in;
         held_delta_ff  <= held_delta_in;
         held_status_ff <= held_status_in;
         led_ff         <= led_in;
         grams_ff       <= grams_in;
         timer_ff       <= timer_in;
      end
   end

endmodule

@@ rtl/scale_weight_packet_framer_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_op, req_sample, req_cmd_packet
// rsp_      out        rsp_valid / rsp_ready  status, weight, delta, parity, ok, flags
// csr_      in         csr_we (no wait)       csr_index, csr_wdata
//
// Each request yields exactly one response, and one request can be taken every
// cycle while rsp_ready is high. A request is held first in the input register
// and then in the response register, where it is offered to the receiver. The
// scale state updates as the request moves from the first to the second. Reset
// is synchronous and returns the registers and scale state to their reset values
// with both stages empty. A stalled response holds its register; the input
// register still fills, and req_ready drops only when both stages are occupied
// and rsp_ready is low.

module scale_weight_packet_framer_unit #(
   parameter int WEIGHT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic signed [15:0]  req_sample,
   input  logic [55:0]         req_cmd_packet,
   // Response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_status_byte,
   output logic signed [15:0]  rsp_tared_weight,
   output logic signed [15:0]  rsp_weight_delta,
   output logic [7:0]          rsp_parity_byte,
   output logic                rsp_cmd_ok,
   output logic                rsp_led_flag,
   output logic                rsp_grams_flag,
   output logic                rsp_timer_flag,
   // Configuration port
   input  logic                csr_we,
   input  logic [swpf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [swpf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers.
   logic [7:0] stable_code_ff;
   logic [7:0] changing_code_ff;
   logic [7:0] tare_opcode_ff;
   logic [7:0] led_opcode_ff;
   logic [7:0] timer_opcode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_code_ff   <= swpf_pkg::STABLE_CODE_RST;
         changing_code_ff <= swpf_pkg::CHANGING_CODE_RST;
         tare_opcode_ff   <= swpf_pkg::TARE_OPCODE_RST;
         led_opcode_ff    <= swpf_pkg::LED_OPCODE_RST;
         timer_opcode_ff  <= swpf_pkg::TIMER_OPCODE_RST;
      end else if (csr_we) begin
         // Indexes past the last register are ignored.
         case (swpf_pkg::csr_index_type'(csr_index))
            swpf_pkg::CSR_STABLE_CODE:   stable_code_ff   <= csr_wdata;
            swpf_pkg::CSR_CHANGING_CODE: changing_code_ff <= csr_wdata;
            swpf_pkg::CSR_TARE_OPCODE:   tare_opcode_ff   <= csr_wdata;
            swpf_pkg::CSR_LED_OPCODE:    led_opcode_ff    <= csr_wdata;
            swpf_pkg::CSR_TIMER_OPCODE:  timer_opcode_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register: holds one request until the core can process it.
   logic               in_valid_ff;
   logic               in_op_ff;
   logic signed [15:0] in_sample_ff;
   logic [55:0]        in_cmd_ff;
   logic               rsp_valid_ff;
   swpf_pkg::rsp_type  rsp_ff;
   swpf_pkg::rsp_type  rsp_in;
   swpf_pkg::cmd_action_type action;
   logic               out_free;
   logic               advance;

   // The response register can load when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff     <= req_op;
         in_sample_ff <= req_sample;
         in_cmd_ff    <= req_cmd_packet;
      end
   end

   swpf_cmd_decode u_decode (
      .cmd_packet   (in_cmd_ff),
      .tare_opcode  (tare_opcode_ff),
      .led_opcode   (led_opcode_ff),
      .timer_opcode (timer_opcode_ff),
      .action       (action)
   );

   swpf_core #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .op            (in_op_ff),
      .sample        (in_sample_ff),
      .action        (action),
      .stable_code   (stable_code_ff),
      .changing_code (changing_code_ff),
      .rsp           (rsp_in)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status_byte  = rsp_ff.status_byte;
   assign rsp_tared_weight = rsp_ff.tared_weight;
   assign rsp_weight_delta = rsp_ff.weight_delta;
   assign rsp_parity_byte  = rsp_ff.parity_byte;
   assign rsp_cmd_ok       = rsp_ff.cmd_ok;
   assign rsp_led_flag     = rsp_ff.led_flag;
   assign rsp_grams_flag   = rsp_ff.grams_flag;
   assign rsp_timer_flag   = rsp_ff.timer_flag;

endmodule

@@ rtl/swpf_checker.sv @@
`timescale 1ns / 1ps

module swpf_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [7:0]          rsp_status_byte,
   input logic signed [15:0]  rsp_tared_weight,
   input logic signed [15:0]  rsp_weight_delta,
   input logic [7:0]          rsp_parity_byte,
   input logic                rsp_grams_flag
);

   // The response stage is empty after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // The parity byte always matches the framed packet.
   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_parity_byte == swpf_pkg::frame_parity(rsp_status_byte,
                       rsp_tared_weight, rsp_weight_delta))
      else $error("packet parity mismatch");

   // The grams display flag starts on and nothing turns it off.
   a_grams_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_grams_flag)
      else $error("grams flag seen low");

   // A stalled response stays valid and unchanged.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status_byte)
         && $stable(rsp_tared_weight) && $stable(rsp_weight_delta))
      else $error("stalled response changed");

endmodule

bind scale_weight_packet_framer_unit swpf_checker u_swpf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status_byte  (rsp_status_byte),
   .rsp_tared_weight (rsp_tared_weight),
   .rsp_weight_delta (rsp_weight_delta),
   .rsp_parity_byte  (rsp_parity_byte),
   .rsp_grams_flag   (rsp_grams_flag)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the scale weight packet framer. Requests are a mix
// of raw weight samples and seven-byte command packets. Each accepted request
// is run through a behavioral copy of the scale state, and the packet it should
// produce is queued. Each accepted response is compared with the oldest queued
// packet, field by field.
module testbench;
   import swpf_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int GAP_MAX      = 12;
   localparam int RANDOM_ITEMS = 1700;
   localparam int PHASES       = 6;
   localparam int BURST_LENGTH = 50;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   // Behavioral copy of the framer. It keeps its own register values and scale
   // state, and it holds the packets that accepted requests still owe.
   class packet_scoreboard;
      logic [7:0]  stable_code, changing_code;
      logic [7:0]  tare_opcode, led_opcode, timer_opcode;
      logic [15:0] last_raw, tare_offset, held_weight, held_delta;
      logic [7:0]  held_status;
      logic        led_on, grams_on, timer_on;
      rsp_type     owed_packets[$];
      int          mismatches;

      function new();
         stable_code   = STABLE_CODE_RST;
         changing_code = CHANGING_CODE_RST;
         tare_opcode   = TARE_OPCODE_RST;
         led_opcode    = LED_OPCODE_RST;
         timer_opcode  = TIMER_OPCODE_RST;
         last_raw      = '0;
         tare_offset   = '0;
         held_weight   = '0;
         held_delta    = '0;
         held_status   = STABLE_CODE_RST;
         led_on        = 1'b0;
         grams_on      = 1'b1;
         timer_on      = 1'b0;
         mismatches    = 0;
      endfunction

      static function logic [7:0] xor_bytes(logic [47:0] bytes);
         logic [7:0] acc;
         acc = '0;
         for (int i = 0; i < 6; i++)
            acc ^= bytes[8*i +: 8];
         return acc;
      endfunction

      function void write_register(csr_index_type index, logic [7:0] value);
         case (index)
            CSR_STABLE_CODE:   stable_code   = value;
            CSR_CHANGING_CODE: changing_code = value;
            CSR_TARE_OPCODE:   tare_opcode   = value;
            CSR_LED_OPCODE:    led_opcode    = value;
            CSR_TIMER_OPCODE:  timer_opcode  = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_packets.size();
      endfunction

      function void note_request(logic op, logic [15:0] sample, logic [55:0] packet);
         rsp_type    framed;
         logic [7:0] code;
         logic       ok;
         ok   = 1'b1;
         code = packet[47:40];
         if (op == OP_SAMPLE) begin
            held_status = (sample == last_raw) ? stable_code : changing_code;
            held_weight = sample - tare_offset;
            held_delta  = sample - last_raw;
            last_raw    = sample;
         end else if (xor_bytes(packet[55:8]) != packet[7:0]) begin
            ok = 1'b0;
         end else if (code == tare_opcode) begin
            tare_offset = last_raw;
            held_weight = '0;
            held_delta  = '0;
            held_status = stable_code;
         end else if (code == led_opcode) begin
            led_on   = 1'b1;
            grams_on = 1'b1;
         end else if (code == timer_opcode) begin
            timer_on = 1'b1;
         end else begin
            ok = 1'b0;
         end
         framed.status_byte  = held_status;
         framed.tared_weight = held_weight;
         framed.weight_delta = held_delta;
         framed.parity_byte  = xor_bytes({HDR_BYTE, held_status, held_weight, held_delta});
         framed.cmd_ok       = ok;
         framed.led_flag     = led_on;
         framed.grams_flag   = grams_on;
         framed.timer_flag   = timer_on;
         owed_packets.push_back(framed);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: %s expected %h, got %h", $time, field, want, got);
         end
      endfunction

      function void check_packet(rsp_type got);
         rsp_type want;
         if (owed_packets.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response %h arrived with no request outstanding", $time, got);
            return;
         end
         want = owed_packets.pop_front();
         compare_field("status_byte",  16'(want.status_byte),  16'(got.status_byte));
         compare_field("tared_weight", want.tared_weight,      got.tared_weight);
         compare_field("weight_delta", want.weight_delta,      got.weight_delta);
         compare_field("parity_byte",  16'(want.parity_byte),  16'(got.parity_byte));
         compare_field("cmd_ok",       16'(want.cmd_ok),       16'(got.cmd_ok));
         compare_field("led_flag",     16'(want.led_flag),     16'(got.led_flag));
         compare_field("grams_flag",   16'(want.grams_flag),   16'(got.grams_flag));
         compare_field("timer_flag",   16'(want.timer_flag),   16'(got.timer_flag));
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_op = OP_SAMPLE;
   logic signed [15:0]        req_sample = '0;
   logic [55:0]               req_cmd_packet = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [7:0]                rsp_status_byte;
   logic signed [15:0]        rsp_tared_weight;
   logic signed [15:0]        rsp_weight_delta;
   logic [7:0]                rsp_parity_byte;
   logic                      rsp_cmd_ok;
   logic                      rsp_led_flag;
   logic                      rsp_grams_flag;
   logic                      rsp_timer_flag;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   packet_scoreboard scoreboard;
   int               idle_cycles = 0;
   // While a burst flag is set, that side of the bench never idles.
   bit               req_burst = 1'b0;
   bit               rsp_burst = 1'b0;
   // The last sample sent, so that repeats can hit the stable status path.
   logic [15:0]      last_sample = '0;

   scale_weight_packet_framer_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_sample       (req_sample),
      .req_cmd_packet   (req_cmd_packet),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_tared_weight (rsp_tared_weight),
      .rsp_weight_delta (rsp_weight_delta),
      .rsp_parity_byte  (rsp_parity_byte),
      .rsp_cmd_ok       (rsp_cmd_ok),
      .rsp_led_flag     (rsp_led_flag),
      .rsp_grams_flag   (rsp_grams_flag),
      .rsp_timer_flag   (rsp_timer_flag),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Handshakes are sampled at the rising edge, where the bench's own inputs
   // have been stable since the previous falling edge. A request is noted
   // before a response is checked, although the two stage pipeline never lets
   // a request and its own response meet in the same cycle anyway.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            scoreboard.note_request(req_op, req_sample, req_cmd_packet);
         if (rsp_valid && rsp_ready) begin
            got.status_byte  = rsp_status_byte;
            got.tared_weight = rsp_tared_weight;
            got.weight_delta = rsp_weight_delta;
            got.parity_byte  = rsp_parity_byte;
            got.cmd_ok       = rsp_cmd_ok;
            got.led_flag     = rsp_led_flag;
            got.grams_flag   = rsp_grams_flag;
            got.timer_flag   = rsp_timer_flag;
            scoreboard.check_packet(got);
         end
         // Any handshake or register write counts as progress for the watchdog.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // The receiver draws a stall before every response, except during bursts.
   // Ready is only ever changed at a falling edge.
   initial begin
      int stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // A hung handshake shows up as a long run of cycles with no progress.
   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // Called at a falling edge. The write lands at the next rising edge, and
   // the task returns at the falling edge after it.
   task automatic write_register(csr_index_type index, logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      scoreboard.write_register(index, value);
      @(negedge clock);
   endtask

   task automatic program_registers(logic [7:0] stable, logic [7:0] changing,
                                    logic [7:0] tare, logic [7:0] led,
                                    logic [7:0] timer);
      write_register(CSR_STABLE_CODE, stable);
      write_register(CSR_CHANGING_CODE, changing);
      write_register(CSR_TARE_OPCODE, tare);
      write_register(CSR_LED_OPCODE, led);
      write_register(CSR_TIMER_OPCODE, timer);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Called at a falling edge. Valid from the previous request is still high
   // here, so a back-to-back request simply keeps it high with a new payload.
   task automatic send_request(logic op, logic [15:0] sample, logic [55:0] packet);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_sample     <= sample;
      req_cmd_packet <= packet;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (op == OP_SAMPLE)
         last_sample = sample;
   endtask

   // The unused command field carries random bits so that it is exercised too.
   task automatic send_sample(logic [15:0] sample);
      send_request(OP_SAMPLE, sample, 56'({$urandom, $urandom}));
   endtask

   // Builds a command with random filler bytes around the opcode. A bad
   // command gets its parity byte flipped by a nonzero amount.
   task automatic send_command(logic [7:0] code, bit good);
      logic [47:0] body;
      logic [7:0]  parity;
      body          = 48'({$urandom, $urandom});
      body[39:32]   = code;
      parity        = packet_scoreboard::xor_bytes(body);
      if (!good)
         parity ^= 8'($urandom_range(1, 255));
      send_request(OP_COMMAND, 16'($urandom), {body, parity});
   endtask

   // Stops new requests and waits until every owed response has come back.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Random mix: most samples sit near the previous one so that stable and
   // small-change packets are common, and most commands are well formed so
   // that tare, LED and timer actually fire. The rest is bad parity or noise.
   task automatic send_random_item();
      int         pick;
      logic [7:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         send_sample(last_sample);
      end else if (pick < 35) begin
         send_sample(last_sample + 16'($urandom_range(0, 20)) - 16'd10);
      end else if (pick < 40) begin
         case ($urandom_range(0, 3))
            0: send_sample(16'h8000);
            1: send_sample(16'h7FFF);
            2: send_sample(16'hFFFF);
            default: send_sample(16'h0000);
         endcase
      end else if (pick < 60) begin
         send_sample(16'($urandom));
      end else if (pick < 88) begin
         case ($urandom_range(0, 5))
            0: code = scoreboard.tare_opcode;
            1, 2: code = scoreboard.led_opcode;
            3, 4: code = scoreboard.timer_opcode;
            default: code = 8'($urandom);
         endcase
         send_command(code, 1'b1);
      end else if (pick < 95) begin
         send_command(8'($urandom), 1'b0);
      end else begin
         send_request(OP_COMMAND, 16'($urandom), 56'({$urandom, $urandom}));
      end
   endtask

   initial begin
      scoreboard = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset register values. The first sample equals
      // the cleared previous sample, so it must come out stable.
      send_sample(16'h0000);
      send_sample(16'h7FFF);
      // Full-scale swing: the change wraps around 16 bits.
      send_sample(16'h8000);
      send_sample(16'h8000);
      // A tare request with broken parity is rejected and changes nothing.
      send_command(scoreboard.tare_opcode, 1'b0);
      send_command(scoreboard.tare_opcode, 1'b1);
      // After a tare at the most negative weight, the tared weight wraps.
      send_sample(16'h7FFF);
      send_sample(16'hFFFF);
      send_command(scoreboard.led_opcode, 1'b1);
      send_command(scoreboard.timer_opcode, 1'b1);
      // An all-zero packet has good parity but no known opcode.
      send_request(OP_COMMAND, 16'hFFFF, 56'h0);
      // An all-ones packet fails parity.
      send_request(OP_COMMAND, 16'h0000, {56{1'b1}});
      send_sample(16'h1234);

      // All three opcodes equal: tare has to win.
      wait_for_responses();
      program_registers(8'h00, 8'hFF, 8'h5A, 8'h5A, 8'h5A);
      send_command(8'h5A, 1'b1);
      send_sample(16'h4321);

      // New codes while a changing status is held: the held status stays as
      // it was until the next sample or tare. LED and timer share an opcode,
      // so LED has to win, and a zero opcode now means tare.
      wait_for_responses();
      program_registers(8'h80, 8'h01, 8'h00, 8'hFF, 8'hFF);
      send_command(8'hFF, 1'b1);
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_command(8'h00, 1'b1);
      send_sample(16'h7FFF);

      // Random part, split into phases with different register settings.
      // The bench drains completely before every register change.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_responses();
         case (phase)
            0: program_registers(STABLE_CODE_RST, CHANGING_CODE_RST, TARE_OPCODE_RST,
                                 LED_OPCODE_RST, TIMER_OPCODE_RST);
            1: program_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            2: program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            3: program_registers(8'($urandom), 8'($urandom), 8'h01, 8'hFE, 8'hFE);
            default: program_registers(8'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom));
         endcase
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            // Now and then one side or both run without idling for a while.
            if (n % BURST_LENGTH == 0) begin
               req_burst = ($urandom_range(0, 3) == 0);
               rsp_burst = ($urandom_range(0, 3) == 0);
            end
            send_random_item();
         end
      end

      req_burst = 1'b0;
      rsp_burst = 1'b0;
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
